[hdl/ps2kmc_pkg.sv]
// shared constants and types for the ps2 keyboard/mouse controller
package ps2kmc_pkg;

  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  // item commands
  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_KEY = 2'd2;
  localparam logic [1:0] CMD_PTR = 2'd3;

  // controller command ports
  localparam logic [7:0] HC_READ_MODE = 8'h20;
  localparam logic [7:0] HC_WRITE_MODE = 8'h60;
  localparam logic [7:0] HC_AUX_LOOP = 8'hD3;
  localparam logic [7:0] HC_AUX_SEND = 8'hD4;
  localparam logic [7:0] HC_AUX_TEST = 8'hA9;
  localparam logic [7:0] HC_AUX_DIS = 8'hA7;
  localparam logic [7:0] HC_AUX_EN = 8'hA8;

  // mouse commands
  localparam logic [7:0] MC_SCALE11 = 8'hE6;
  localparam logic [7:0] MC_SET_RES = 8'hE8;
  localparam logic [7:0] MC_STATUS = 8'hE9;
  localparam logic [7:0] MC_GET_ID = 8'hF2;
  localparam logic [7:0] MC_SET_RATE = 8'hF3;
  localparam logic [7:0] MC_ENABLE = 8'hF4;
  localparam logic [7:0] MC_DISABLE = 8'hF5;
  localparam logic [7:0] MC_DEFAULTS = 8'hF6;
  localparam logic [7:0] MC_RESET = 8'hFF;

  localparam logic [7:0] BYTE_ACK = 8'hFA;
  localparam logic [7:0] BYTE_ID0 = 8'hAB;
  localparam logic [7:0] BYTE_ID1 = 8'h41;
  localparam logic [7:0] BYTE_EXT = 8'hE0;
  localparam logic [7:0] BYTE_BRK = 8'hF0;
  localparam logic [7:0] DEF_RATE = 8'd100;
  localparam logic [7:0] DEF_RES = 8'd2;
  localparam logic [7:0] DEF_MODE = 8'h03;

  localparam logic [1:0] ARG_NONE = 2'd0;
  localparam logic [1:0] ARG_RES = 2'd1;
  localparam logic [1:0] ARG_RATE = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;      // latch item, decode plan
    logic       push;      // push current planned byte
    logic       pop;       // issue queue read for data port
    logic       finish;    // present result
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       more;      // more bytes planned
    logic       is_pop;    // item reads the data port
  } dp_stat_t;

endpackage

[hdl/ps2_keyboard_mouse_controller_unit.sv]
// ps2 keyboard/mouse controller top level
// sequence: load, then one push per planned byte (or a pop and a finish step for a data read), then done
// a new word is accepted only in idle, after the previous result has been presented
// reset: asynchronous active low, queues empty, registers at defaults, no clearing pass
// results are strobed by done_o for one cycle; the receiver cannot stall
module ps2_keyboard_mouse_controller_unit import ps2kmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [1:0]  command_i,
  input  logic        port_select_i,
  input  logic [7:0]  write_value_i,
  input  logic [7:0]  key_code_i,
  input  logic        key_extended_i,
  input  logic        key_released_i,
  input  logic [2:0]  button_mask_i,
  input  logic [15:0] pointer_x_i,
  input  logic [15:0] pointer_y_i,
  output logic [7:0]  read_data_o,
  output logic        kbd_irq_o,
  output logic        aux_irq_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ps2kmc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .cmd_o(cmd),
    .busy_o(busy), .done_o
  );

  ps2kmc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .command_i, .port_select_i, .write_value_i, .key_code_i, .key_extended_i,
    .key_released_i, .button_mask_i, .pointer_x_i, .pointer_y_i,
    .read_data_o, .kbd_irq_o, .aux_irq_o
  );

`ifndef SYNTH
  // an accepted word makes the unit busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("start not taken");
  // done lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  // aux interrupt excludes keyboard interrupt
  a_irq_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(kbd_irq_o && aux_irq_o)) else $error("both irqs");
`endif

endmodule

[hdl/ps2kmc_datapath.sv]
// queues, controller registers and byte planning
module ps2kmc_datapath import ps2kmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_stat_t   stat_o,
  input  logic [1:0] command_i,
  input  logic       port_select_i,
  input  logic [7:0] write_value_i,
  input  logic [7:0] key_code_i,
  input  logic       key_extended_i,
  input  logic       key_released_i,
  input  logic [2:0] button_mask_i,
  input  logic [15:0] pointer_x_i,
  input  logic [15:0] pointer_y_i,
  output logic [7:0] read_data_o,
  output logic       kbd_irq_o,
  output logic       aux_irq_o
);

  logic [7:0] kbd_mem [QUEUE_DEPTH];
  logic [7:0] mouse_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] kbd_rd_q, kbd_wr_q, mouse_rd_q, mouse_wr_q;
  logic [FILL_W-1:0] kbd_fill_q, mouse_fill_q;
  logic [7:0] last_kbd_q, mode_q, pend_q, mstat_q, mres_q, mrate_q;
  logic [1:0] arg_q;
  logic [15:0] prev_x_q, prev_y_q;
  logic prev_valid_q;

  // planned byte list: up to four bytes with a target queue each
  logic [7:0] plan_q [4];
  logic [3:0] pmouse_q;
  logic [2:0] pcnt_q, pidx_q;
  logic [7:0] plan_d [4];
  logic [3:0] pmouse_d;
  logic [2:0] pcnt_d;
  logic is_pop_q, from_kbd_q, port_q;
  logic [7:0] kbd_rdata_q, mouse_rdata_q;
  logic [7:0] rd_q;

  // pointer deltas
  logic signed [16:0] dx, dy;
  logic [7:0] flags;
  assign dx = $signed({1'b0, pointer_x_i}) - $signed({1'b0, prev_x_q});
  assign dy = $signed({1'b0, prev_y_q}) - $signed({1'b0, pointer_y_i});
  always_comb begin
    flags = {5'b00001, button_mask_i};
    if (dy > 17'sd255 || dy < -17'sd256) flags[7] = 1'b1;
    if (dx > 17'sd255 || dx < -17'sd256) flags[6] = 1'b1;
    if (dy[16]) flags[5] = 1'b1;
    if (dx[16]) flags[4] = 1'b1;
  end

  // decode the item into a list of pushes
  always_comb begin
    for (int i = 0; i < 4; i++) plan_d[i] = 8'h00;
    pmouse_d = 4'b0000;
    pcnt_d = 3'd0;
    case (command_i)
      CMD_WRITE: begin
        if (port_select_i) begin
          if (write_value_i == HC_READ_MODE) begin
            plan_d[0] = mode_q; pcnt_d = 3'd1;
          end else if (write_value_i == HC_AUX_TEST) begin
            plan_d[0] = 8'h00; pmouse_d = 4'b0001; pcnt_d = 3'd1;
          end
        end else begin
          case (pend_q)
            HC_AUX_LOOP: begin
              plan_d[0] = write_value_i; plan_d[1] = BYTE_ACK;
              pmouse_d = 4'b0011; pcnt_d = 3'd2;
            end
            HC_AUX_SEND: begin
              plan_d[0] = BYTE_ACK; pmouse_d = 4'b1111; pcnt_d = 3'd1;
              if (arg_q == ARG_NONE) begin
                if (write_value_i == MC_STATUS) begin
                  plan_d[1] = mstat_q; plan_d[2] = mres_q; plan_d[3] = mrate_q;
                  pcnt_d = 3'd4;
                end else if (write_value_i == MC_GET_ID) begin
                  pcnt_d = 3'd2;
                end
              end
            end
            8'h00: begin
              plan_d[0] = BYTE_ACK; plan_d[1] = BYTE_ID0; plan_d[2] = BYTE_ID1;
              pcnt_d = 3'd3;
            end
            default: ;
          endcase
        end
      end
      CMD_KEY: begin
        if (key_extended_i) begin
          plan_d[pcnt_d[1:0]] = BYTE_EXT; pcnt_d = pcnt_d + 3'd1;
        end
        if (key_code_i != 8'h00) begin
          if (key_released_i) begin
            plan_d[pcnt_d[1:0]] = BYTE_BRK; pcnt_d = pcnt_d + 3'd1;
          end
          plan_d[pcnt_d[1:0]] = key_code_i; pcnt_d = pcnt_d + 3'd1;
        end
      end
      CMD_PTR: begin
        if (prev_valid_q) begin
          plan_d[0] = flags; plan_d[1] = dx[7:0]; plan_d[2] = dy[7:0];
          pmouse_d = 4'b0111; pcnt_d = 3'd3;
        end
      end
      default: ;
    endcase
  end

  logic [7:0] cur_byte;
  logic cur_mouse;
  assign cur_byte = plan_q[pidx_q[1:0]];
  assign cur_mouse = pmouse_q[pidx_q[1:0]];
  assign stat_o.more = pidx_q < pcnt_q;
  assign stat_o.is_pop = is_pop_q;

  logic kpush, mpush, kpop, mpop;
  assign kpush = cmd_i.push && !cur_mouse && (kbd_fill_q != FILL_W'(QUEUE_DEPTH));
  assign mpush = cmd_i.push && cur_mouse && (mouse_fill_q != FILL_W'(QUEUE_DEPTH));
  assign kpop = cmd_i.pop && (kbd_fill_q != '0);
  assign mpop = cmd_i.pop && (kbd_fill_q == '0) && (mouse_fill_q != '0);

  // queue memories
  always_ff @(posedge clk_i) begin
    if (kpush) kbd_mem[kbd_wr_q] <= cur_byte;
    kbd_rdata_q <= kbd_mem[kbd_rd_q];
  end
  always_ff @(posedge clk_i) begin
    if (mpush) mouse_mem[mouse_wr_q] <= cur_byte;
    mouse_rdata_q <= mouse_mem[mouse_rd_q];
  end

  // plan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      plan_q <= plan_d;
      pmouse_q <= pmouse_d;
    end
  end

  // control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbd_rd_q <= '0; kbd_wr_q <= '0; kbd_fill_q <= '0;
      mouse_rd_q <= '0; mouse_wr_q <= '0; mouse_fill_q <= '0;
      last_kbd_q <= '0; mode_q <= DEF_MODE; pend_q <= '0;
      mstat_q <= '0; mres_q <= DEF_RES; mrate_q <= DEF_RATE; arg_q <= ARG_NONE;
      prev_x_q <= '0; prev_y_q <= '0; prev_valid_q <= 1'b0;
      pcnt_q <= '0; pidx_q <= '0; is_pop_q <= 1'b0;
      from_kbd_q <= 1'b0; port_q <= 1'b0; rd_q <= '0;
    end else begin
      if (cmd_i.load) begin
        pcnt_q <= pcnt_d;
        pidx_q <= '0;
        is_pop_q <= (command_i == CMD_READ);
        port_q <= port_select_i;
        rd_q <= '0;
        if (command_i == CMD_READ && port_select_i) begin
          rd_q <= {2'b00, kbd_fill_q == '0 && mouse_fill_q != '0, 3'b111, 2'b00}
                  | {7'd0, kbd_fill_q != '0 || mouse_fill_q != '0};
          is_pop_q <= 1'b0;
        end
        if (command_i == CMD_WRITE) begin
          if (port_select_i) begin
            case (write_value_i)
              HC_WRITE_MODE, HC_AUX_LOOP, HC_AUX_SEND: pend_q <= write_value_i;
              HC_AUX_DIS: mode_q <= mode_q | 8'h20;
              HC_AUX_EN:  mode_q <= mode_q & 8'hDF;
              default: ;
            endcase
          end else begin
            pend_q <= '0;
            if (pend_q == HC_WRITE_MODE) mode_q <= write_value_i;
            if (pend_q == HC_AUX_SEND) begin
              arg_q <= ARG_NONE;
              if (arg_q == ARG_RES) mres_q <= write_value_i;
              else if (arg_q == ARG_RATE) mrate_q <= write_value_i;
              else begin
                case (write_value_i)
                  MC_SCALE11: mstat_q <= mstat_q & 8'hEF;
                  MC_SET_RES: arg_q <= ARG_RES;
                  MC_SET_RATE: arg_q <= ARG_RATE;
                  MC_ENABLE: mstat_q <= mstat_q | 8'h20;
                  MC_DISABLE: mstat_q <= mstat_q & 8'hDF;
                  MC_DEFAULTS, MC_RESET: begin
                    mstat_q <= '0; mres_q <= DEF_RES; mrate_q <= DEF_RATE;
                  end
                  default: ;
                endcase
              end
            end
          end
        end
        if (command_i == CMD_PTR) begin
          prev_x_q <= pointer_x_i; prev_y_q <= pointer_y_i; prev_valid_q <= 1'b1;
        end
      end
      if (cmd_i.push) begin
        pidx_q <= pidx_q + 3'd1;
        if (kpush) begin
          kbd_wr_q <= kbd_wr_q + 1'b1; kbd_fill_q <= kbd_fill_q + 1'b1;
        end
        if (mpush) begin
          mouse_wr_q <= mouse_wr_q + 1'b1; mouse_fill_q <= mouse_fill_q + 1'b1;
        end
      end
      if (cmd_i.pop) begin
        from_kbd_q <= kpop;
        port_q <= kpop | mpop;
        if (kpop) begin
          kbd_rd_q <= kbd_rd_q + 1'b1; kbd_fill_q <= kbd_fill_q - 1'b1;
        end
        if (mpop) begin
          mouse_rd_q <= mouse_rd_q + 1'b1; mouse_fill_q <= mouse_fill_q - 1'b1;
        end
      end
      // data read result: the queue read registered at the pop edge is taken on finish
      if (cmd_i.finish && is_pop_q) begin
        if (!port_q) rd_q <= last_kbd_q;
        else if (from_kbd_q) begin
          rd_q <= kbd_rdata_q; last_kbd_q <= kbd_rdata_q;
        end else rd_q <= mouse_rdata_q;
      end
    end
  end

  assign read_data_o = rd_q;
  assign kbd_irq_o = kbd_fill_q != '0;
  assign aux_irq_o = (kbd_fill_q == '0) && (mouse_fill_q != '0);

endmodule

[hdl/ps2kmc_ctrl.sv]
// sequencer: load, push bytes or pop, then present result
module ps2kmc_ctrl import ps2kmc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUSH = 3'd1;
  localparam logic [2:0] S_FIN = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: if (start_i) begin
        cmd_o.load = 1'b1; state_d = S_PUSH;
      end
      S_PUSH: begin
        if (stat_i.is_pop) begin
          cmd_o.pop = 1'b1; state_d = S_FIN;
        end else if (stat_i.more) cmd_o.push = 1'b1;
        else begin
          cmd_o.finish = 1'b1; state_d = S_DONE;
        end
      end
      // queue read data registered at the pop edge is taken here
      S_FIN: begin
        cmd_o.finish = 1'b1; state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;

endmodule
